/* rtl/core/lccg_pkg.sv */
// ----------------------------------------------------------------------------
// lccg_pkg - shared constants for the link constraint contact generator
// Output field widths, register indexes and link kinds.
// ----------------------------------------------------------------------------
`default_nettype none
package lccg_pkg;
	localparam int PEN_W   = 25;
	localparam int NORM_W  = 16;
	localparam int REST_W  = 16;
	localparam int Q_BITS  = 15;
	localparam int UNIT_SH = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam logic [PEN_W-1:0] PEN_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINK_KIND   = 2'd0,
		CFG_MAX_LENGTH  = 2'd1,
		CFG_RESTITUTION = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_index_t;

	typedef enum logic {
		LINK_CABLE = 1'b0,
		LINK_ROD   = 1'b1
	} link_kind_t;
endpackage
`default_nettype wire

/* rtl/core/lccg_ifs.sv */
// ----------------------------------------------------------------------------
// lccg interfaces - link input channel and contact output channel
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface lccg_link_if #(parameter int POS_WIDTH = 24);
	logic valid;
	logic ready;
	logic signed [POS_WIDTH-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface lccg_contact_if;
	logic valid;
	logic ready;
	logic signed [lccg_pkg::NORM_W-1:0] normal_x, normal_y, normal_z;
	logic [lccg_pkg::PEN_W-1:0] penetration;
	logic [lccg_pkg::REST_W-1:0] contact_restitution;
	modport source(output valid, normal_x, normal_y, normal_z, penetration,
		contact_restitution, input ready);
	modport sink(input valid, normal_x, normal_y, normal_z, penetration,
		contact_restitution, output ready);
endinterface
`default_nettype wire

/* rtl/core/lccg_isqrt.sv */
// ----------------------------------------------------------------------------
// lccg_isqrt - pipelined floor square root
// One root bit per stage, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module lccg_isqrt #(
	parameter int SW = 50,
	parameter int SB = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [SW-1:0]     radicand,
	input  wire logic [SB-1:0]     in_side,
	output logic                   out_valid,
	output logic [SW/2-1:0]        root,
	output logic [SB-1:0]          out_side
);
	localparam int RW = SW / 2;

	logic            v_s    [RW+1];
	logic [SW-1:0]   rad_s  [RW+1];
	logic [RW+1:0]   rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [SB-1:0]   side_s [RW+1];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 1; k <= RW; k++) begin : g_stage
		logic [RW+1:0] r2, trial;
		logic          take;
		assign r2    = {rem_s[k-1][RW-1:0], rad_s[k-1][SW-1 -: 2]};
		assign trial = {root_s[k-1], 2'b01};
		assign take  = (r2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_s[k-1][SW-3:0], 2'b00};
				rem_s[k]  <= take ? (r2 - trial) : r2;
				root_s[k] <= {root_s[k-1][RW-2:0], take};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign out_side  = side_s[RW];
endmodule
`default_nettype wire

/* rtl/core/link_constraint_contact_generation_unit.sv */
// ----------------------------------------------------------------------------
// link_constraint_contact_generation_unit - cable / rod contact generator
// Distance by floor square root, normal by long division, one link a cycle.
// ----------------------------------------------------------------------------
// From input word to contact word: difference, square and sum stages, the
// square-root stages, stage 4, the division stages and the output register.
// Throughput: one link word per cycle; the whole pipeline holds while the
// output word waits, so input ready follows output ready.
// Reset: arst_n clears every stage valid bit and the three registers to 0.
`default_nettype none
module link_constraint_contact_generation_unit #(
	parameter int POS_WIDTH = 24,
	parameter int FRAC_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lccg_link_if.sink      in_link,
	lccg_contact_if.source out_contact,
	input  wire logic                             cfg_we,
	input  wire logic [lccg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lccg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int P   = POS_WIDTH;
	localparam int SW  = 2 * P + 2;   // sum of three squares
	localparam int RW  = P + 1;       // distance
	localparam int QB  = lccg_pkg::Q_BITS;
	localparam int PW  = lccg_pkg::PEN_W;
	localparam int CW  = (RW > PW) ? RW : PW;
	localparam int SB  = 3 * (P + 1) + 3;
	// lengths and positions share one scale, so the fraction width is only
	// a statement of format here
	localparam int FRAC_UNUSED = FRAC_BITS;

	// configuration registers
	lccg_pkg::link_kind_t         kind_q;
	logic [PW-1:0]                max_len_q;
	logic [lccg_pkg::REST_W-1:0]  rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= lccg_pkg::LINK_CABLE;
			max_len_q <= '0;
			rest_q    <= '0;
		end else if (cfg_we) begin
			case (lccg_pkg::cfg_index_t'(cfg_index))
				lccg_pkg::CFG_LINK_KIND:   kind_q    <= lccg_pkg::link_kind_t'(cfg_data[0]);
				lccg_pkg::CFG_MAX_LENGTH:  max_len_q <= cfg_data[PW-1:0];
				lccg_pkg::CFG_RESTITUTION: rest_q    <= cfg_data[lccg_pkg::REST_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipe when the output word is empty or being taken
	logic adv;
	logic out_valid_q;
	assign adv = !out_valid_q || out_contact.ready;
	assign in_link.ready = adv;

	// stage 1: differences B - A as magnitude and sign
	logic           v_s1;
	logic [P:0]     mag_s1 [3];
	logic           sgn_s1 [3];
	logic signed [P:0] d_c [3];

	assign d_c[0] = {in_link.b_x[P-1], in_link.b_x} - {in_link.a_x[P-1], in_link.a_x};
	assign d_c[1] = {in_link.b_y[P-1], in_link.b_y} - {in_link.a_y[P-1], in_link.a_y};
	assign d_c[2] = {in_link.b_z[P-1], in_link.b_z} - {in_link.a_z[P-1], in_link.a_z};

	// stage 2: squares; stage 3: sum
	logic           v_s2, v_s3;
	logic [SW-1:0]  sq_s2 [3];
	logic [P:0]     mag_s2 [3];
	logic           sgn_s2 [3];
	logic [SW-1:0]  sum_s3;
	logic [P:0]     mag_s3 [3];
	logic           sgn_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_link.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sgn_s1[i] <= d_c[i][P];
				mag_s1[i] <= d_c[i][P] ? (P+1)'(-d_c[i]) : (P+1)'(d_c[i]);
				sq_s2[i]  <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
				mag_s2[i] <= mag_s1[i];
				sgn_s2[i] <= sgn_s1[i];
				mag_s3[i] <= mag_s2[i];
				sgn_s3[i] <= sgn_s2[i];
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// square root stages, components ride along as sideband
	logic          v_rt;
	logic [RW-1:0] dist_rt;
	logic [SB-1:0] side_rt;

	lccg_isqrt #(.SW(SW), .SB(SB)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.radicand (sum_s3),
		.in_side  ({mag_s3[0], mag_s3[1], mag_s3[2], sgn_s3[0], sgn_s3[1], sgn_s3[2]}),
		.out_valid(v_rt),
		.root     (dist_rt),
		.out_side (side_rt)
	);

	logic [P:0] mag_rt [3];
	logic       sgn_rt [3];
	assign {mag_rt[0], mag_rt[1], mag_rt[2], sgn_rt[0], sgn_rt[1], sgn_rt[2]} = side_rt;

	// stage 4: contact decision, penetration and saturation
	logic [CW:0] dist_w, maxl_w, diff_pos, diff_neg, pen_full;
	logic        longer, equal, emit_c, flip_c;
	logic [PW-1:0] pen_c;

	assign dist_w   = (CW+1)'(dist_rt);
	assign maxl_w   = (CW+1)'(max_len_q);
	assign longer   = dist_w > maxl_w;
	assign equal    = dist_w == maxl_w;
	assign diff_pos = dist_w - maxl_w;
	assign diff_neg = maxl_w - dist_w;
	assign emit_c   = (kind_q == lccg_pkg::LINK_CABLE) ? (longer || equal) : !equal;
	assign flip_c   = (kind_q == lccg_pkg::LINK_ROD) && !longer;
	assign pen_full = flip_c ? diff_neg : diff_pos;
	assign pen_c    = (pen_full > (CW+1)'(lccg_pkg::PEN_MAX)) ? lccg_pkg::PEN_MAX
		: pen_full[PW-1:0];

	// division stages: index 0 is the stage-4 register, one quotient bit each
	logic                        v_s5    [QB+1];
	logic                        emit_s5 [QB+1];
	logic                        flip_s5 [QB+1];
	logic [PW-1:0]               pen_s5  [QB+1];
	logic [lccg_pkg::REST_W-1:0] rst_s5  [QB+1];
	logic [RW-1:0]               dist_s5 [QB+1];
	logic [RW-1:0]               rem_s5  [QB+1][3];
	logic [QB-1:0]               quo_s5  [QB+1][3];
	logic                        lsb_s5  [QB+1][3];
	logic                        sgn_s5  [QB+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5[0] <= 1'b0;
		end else if (adv) begin
			v_s5[0] <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s5[0] <= emit_c;
			flip_s5[0] <= flip_c;
			pen_s5[0]  <= pen_c;
			rst_s5[0]  <= (kind_q == lccg_pkg::LINK_CABLE) ? rest_q : '0;
			dist_s5[0] <= dist_rt;
			for (int i = 0; i < 3; i++) begin
				// mag <= dist, so the top bits of mag << 14 start below dist
				rem_s5[0][i] <= RW'(mag_rt[i][P:1]);
				lsb_s5[0][i] <= mag_rt[i][0];
				quo_s5[0][i] <= '0;
				sgn_s5[0][i] <= sgn_rt[i];
			end
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_div
		logic [RW:0] r2 [3];
		logic        take [3];
		for (genvar i = 0; i < 3; i++) begin : g_lane
			// the odd bit of the magnitude enters first, then zeros
			assign r2[i]   = {rem_s5[j-1][i], (j == 1) ? lsb_s5[j-1][i] : 1'b0};
			assign take[i] = r2[i] >= (RW+1)'(dist_s5[j-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5[j] <= 1'b0;
			end else if (adv) begin
				v_s5[j] <= v_s5[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				emit_s5[j] <= emit_s5[j-1];
				flip_s5[j] <= flip_s5[j-1];
				pen_s5[j]  <= pen_s5[j-1];
				rst_s5[j]  <= rst_s5[j-1];
				dist_s5[j] <= dist_s5[j-1];
				for (int i = 0; i < 3; i++) begin
					rem_s5[j][i] <= take[i] ? RW'(r2[i] - (RW+1)'(dist_s5[j-1]))
						: RW'(r2[i]);
					quo_s5[j][i] <= {quo_s5[j-1][i][QB-2:0], take[i]};
					lsb_s5[j][i] <= lsb_s5[j-1][i];
					sgn_s5[j][i] <= sgn_s5[j-1][i];
				end
			end
		end
	end

	// output word: apply sign, zero normal for coincident particles,
	// drop links that raise no contact
	logic signed [lccg_pkg::NORM_W-1:0] norm_c [3];
	for (genvar i = 0; i < 3; i++) begin : g_norm
		logic [lccg_pkg::NORM_W-1:0] qv;
		assign qv = lccg_pkg::NORM_W'(quo_s5[QB][i]);
		assign norm_c[i] = (dist_s5[QB] == '0) ? '0
			: ((sgn_s5[QB][i] ^ flip_s5[QB]) ? -qv : qv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s5[QB] && emit_s5[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_contact.normal_x            <= norm_c[0];
			out_contact.normal_y            <= norm_c[1];
			out_contact.normal_z            <= norm_c[2];
			out_contact.penetration         <= pen_s5[QB];
			out_contact.contact_restitution <= rst_s5[QB];
		end
	end

	assign out_contact.valid = out_valid_q;

	// a rod never carries restitution
	a_rod_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_contact.valid && (kind_q == lccg_pkg::LINK_ROD)
		|-> out_contact.contact_restitution == '0)
		else $error("rod contact with restitution");

	// normal components stay within one unit
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_contact.valid |-> (out_contact.normal_x <= 16'sd16384)
			&& (out_contact.normal_x >= -16'sd16384)
			&& (out_contact.normal_y <= 16'sd16384)
			&& (out_contact.normal_y >= -16'sd16384)
			&& (out_contact.normal_z <= 16'sd16384)
			&& (out_contact.normal_z >= -16'sd16384))
		else $error("normal out of range");

	// a stalled output word freezes the pipe, including the stage before it
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_contact.valid && !out_contact.ready |=> out_contact.valid
			&& $stable(out_contact.penetration) && $stable(v_s5[QB]))
		else $error("pipe moved under stall");

	logic unused_ok;
	assign unused_ok = (FRAC_UNUSED >= 0);
	a_cfg_frac: assert property (@(posedge clk) unused_ok)
		else $error("bad fraction width");
endmodule
`default_nettype wire
